// ===== hdl/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg: shared types and constants for the I2C master bit sequencer
// Command codes, pin actions, result record and phase table.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int TICK_W        = 16;
	localparam int STEP_W        = 5;
	localparam int CMD_W         = 3;

	localparam logic [TICK_W-1:0] TICKS_RESET = TICK_W'(2);

	// command codes; OP_IDLE doubles as the plain tick request
	typedef enum logic [CMD_W-1:0] {
		OP_IDLE    = 3'd0,
		OP_START   = 3'd1,
		OP_STOP    = 3'd2,
		OP_WRITE   = 3'd3,
		OP_READ    = 3'd4,
		OP_ACK     = 3'd5,
		OP_NACK    = 3'd6,
		OP_WAITACK = 3'd7
	} op_t;

	// what a phase does when it begins
	typedef enum logic [2:0] {
		ACT_SDA0,
		ACT_SDA1,
		ACT_SCL0,
		ACT_SCL1,
		ACT_RX,
		ACT_ACKS
	} act_t;

	typedef struct packed {
		logic                     scl_level;
		logic                     sda_level;
		logic                     sda_released;
		logic                     busy_res;
		logic                     done_res;
		logic [BITS_PER_BYTE-1:0] rx_byte;
		logic                     ack_level;
	} res_t;

	// number of phases in each command sequence
	function automatic logic [STEP_W-1:0] phase_count(input op_t op);
		logic [STEP_W-1:0] n;
		case (op)
			OP_START:   n = STEP_W'(4);
			OP_STOP:    n = STEP_W'(3);
			OP_WRITE:   n = STEP_W'(3 * BITS_PER_BYTE);
			OP_READ:    n = STEP_W'(1 + 3 * BITS_PER_BYTE);
			OP_ACK:     n = STEP_W'(3);
			OP_NACK:    n = STEP_W'(3);
			OP_WAITACK: n = STEP_W'(4);
			default:    n = '0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/i2cms_engine.sv =====
// ----------------------------------------------------------------------------
// i2cms_engine: command and phase state of the I2C master bit sequencer
// Holds the sequencer state and works one request per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_engine (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               fire,
	input  wire logic [i2cms_pkg::CMD_W-1:0]        cmd,
	input  wire logic [i2cms_pkg::BITS_PER_BYTE-1:0] tx_byte,
	input  wire logic                               sda_in,
	input  wire logic [i2cms_pkg::TICK_W-1:0]       ticks_per_phase,
	output logic                                    has_result,
	output i2cms_pkg::res_t                         res
);

	i2cms_pkg::op_t                          op_q, op_d;
	logic [i2cms_pkg::STEP_W-1:0]            step_q, step_d, step_inc;
	logic [i2cms_pkg::TICK_W-1:0]            tick_q, tick_d, tick_inc, len;
	logic [i2cms_pkg::BITS_PER_BYTE-1:0]     shift_q, shift_d, tx_q, tx_d;
	logic                                    scl_q, scl_d, sda_q, sda_d;
	logic                                    rel_q, rel_d, ack_q, ack_d;
	logic                                    done, run_phase;
	i2cms_pkg::op_t                          cmd_e;
	i2cms_pkg::act_t                         act;
	logic [i2cms_pkg::STEP_W-1:0]            t5;
	logic [8:0]                              prod;
	logic [3:0]                              quo;
	logic [i2cms_pkg::STEP_W-1:0]            rem;
	logic [2:0]                              bit_idx;

	assign cmd_e = i2cms_pkg::op_t'(cmd);

	always_comb begin
		op_d       = op_q;
		step_d     = step_q;
		tick_d     = tick_q;
		shift_d    = shift_q;
		tx_d       = tx_q;
		scl_d      = scl_q;
		sda_d      = sda_q;
		rel_d      = rel_q;
		ack_d      = ack_q;
		done       = 1'b0;
		has_result = 1'b0;
		run_phase  = 1'b0;
		len        = (ticks_per_phase == '0) ? i2cms_pkg::TICK_W'(1) : ticks_per_phase;
		tick_inc   = tick_q + i2cms_pkg::TICK_W'(1);
		step_inc   = step_q + i2cms_pkg::STEP_W'(1);

		if (cmd_e != i2cms_pkg::OP_IDLE) begin
			// commands are only taken when idle; otherwise dropped silently
			if (op_q == i2cms_pkg::OP_IDLE) begin
				has_result = 1'b1;
				op_d       = cmd_e;
				step_d     = '0;
				tick_d     = '0;
				rel_d      = 1'b0;
				run_phase  = 1'b1;
				if (cmd_e == i2cms_pkg::OP_WRITE) begin
					tx_d = tx_byte;
				end
				if (cmd_e == i2cms_pkg::OP_READ) begin
					shift_d = '0;
				end
			end
		end else begin
			has_result = 1'b1;
			if (op_q != i2cms_pkg::OP_IDLE) begin
				tick_d = tick_inc;
				if (tick_inc >= len) begin
					tick_d = '0;
					step_d = step_inc;
					if (step_inc >= i2cms_pkg::phase_count(op_q)) begin
						op_d   = i2cms_pkg::OP_IDLE;
						step_d = '0;
						done   = 1'b1;
					end else begin
						run_phase = 1'b1;
					end
				end
			end
		end

		// bit index and position within a three-phase bit slot
		t5 = (op_d == i2cms_pkg::OP_READ) ? (step_d - i2cms_pkg::STEP_W'(1)) : step_d;
		prod    = 9'(t5) * 9'd11;          // floor(x/3) for x < 32
		quo     = prod[8:5];
		rem     = t5 - ({1'b0, quo} + {quo, 1'b0});
		bit_idx = 3'd7 - quo[2:0];

		case (op_d)
			i2cms_pkg::OP_START: begin
				case (step_d[1:0])
					2'd0:    act = i2cms_pkg::ACT_SDA1;
					2'd1:    act = i2cms_pkg::ACT_SCL1;
					2'd2:    act = i2cms_pkg::ACT_SDA0;
					default: act = i2cms_pkg::ACT_SCL0;
				endcase
			end
			i2cms_pkg::OP_STOP: begin
				if (step_d == '0) begin
					act = i2cms_pkg::ACT_SDA0;
				end else if (step_d == i2cms_pkg::STEP_W'(1)) begin
					act = i2cms_pkg::ACT_SCL1;
				end else begin
					act = i2cms_pkg::ACT_SDA1;
				end
			end
			i2cms_pkg::OP_WRITE: begin
				if (rem == '0) begin
					act = tx_d[bit_idx] ? i2cms_pkg::ACT_SDA1 : i2cms_pkg::ACT_SDA0;
				end else if (rem == i2cms_pkg::STEP_W'(1)) begin
					act = i2cms_pkg::ACT_SCL1;
				end else begin
					act = i2cms_pkg::ACT_SCL0;
				end
			end
			i2cms_pkg::OP_READ: begin
				if (step_d == '0) begin
					act = i2cms_pkg::ACT_SDA1;
				end else if (rem == '0) begin
					act = i2cms_pkg::ACT_SCL1;
				end else if (rem == i2cms_pkg::STEP_W'(1)) begin
					act = i2cms_pkg::ACT_RX;
				end else begin
					act = i2cms_pkg::ACT_SCL0;
				end
				if (run_phase && step_d == i2cms_pkg::STEP_W'(1)) begin
					rel_d = 1'b1;
				end
			end
			i2cms_pkg::OP_ACK, i2cms_pkg::OP_NACK: begin
				if (step_d == '0) begin
					act = (op_d == i2cms_pkg::OP_ACK) ? i2cms_pkg::ACT_SDA0
					                                  : i2cms_pkg::ACT_SDA1;
				end else if (step_d == i2cms_pkg::STEP_W'(1)) begin
					act = i2cms_pkg::ACT_SCL1;
				end else begin
					act = i2cms_pkg::ACT_SCL0;
				end
			end
			i2cms_pkg::OP_WAITACK: begin
				case (step_d[1:0])
					2'd0:    act = i2cms_pkg::ACT_SDA1;
					2'd1:    act = i2cms_pkg::ACT_SCL1;
					2'd2:    act = i2cms_pkg::ACT_ACKS;
					default: act = i2cms_pkg::ACT_SCL0;
				endcase
				if (run_phase && step_d[1:0] == 2'd2) begin
					rel_d = 1'b1;
				end
			end
			default: act = i2cms_pkg::ACT_SCL0;
		endcase

		if (run_phase) begin
			case (act)
				i2cms_pkg::ACT_SDA0: sda_d = 1'b0;
				i2cms_pkg::ACT_SDA1: sda_d = 1'b1;
				i2cms_pkg::ACT_SCL0: scl_d = 1'b0;
				i2cms_pkg::ACT_SCL1: scl_d = 1'b1;
				i2cms_pkg::ACT_RX: begin
					if (sda_in) begin
						shift_d[bit_idx] = 1'b1;
					end
				end
				default: ack_d = sda_in;
			endcase
		end

		res.scl_level    = scl_d;
		res.sda_level    = sda_d;
		res.sda_released = rel_d;
		res.busy_res     = (op_d != i2cms_pkg::OP_IDLE);
		res.done_res     = done;
		res.rx_byte      = shift_d;
		res.ack_level    = ack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= i2cms_pkg::OP_IDLE;
			step_q  <= '0;
			tick_q  <= '0;
			shift_q <= '0;
			tx_q    <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			rel_q   <= 1'b0;
			ack_q   <= 1'b0;
		end else if (fire) begin
			op_q    <= op_d;
			step_q  <= step_d;
			tick_q  <= tick_d;
			shift_q <= shift_d;
			tx_q    <= tx_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			rel_q   <= rel_d;
			ack_q   <= ack_d;
		end
	end

	// idle means a clean phase position
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(op_q == i2cms_pkg::OP_IDLE) |-> (step_q == '0 && tick_q == '0))
		else $error("idle with nonzero phase state");

	// running step never reaches the end of its sequence
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(op_q != i2cms_pkg::OP_IDLE) |-> (step_q < i2cms_pkg::phase_count(op_q)))
		else $error("phase step out of range");

	// a command during a sequence leaves the sequence untouched
	a_busy_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd_e != i2cms_pkg::OP_IDLE && op_q != i2cms_pkg::OP_IDLE)
		|=> ($stable(op_q) && $stable(step_q) && $stable(tick_q)))
		else $error("command taken while busy");

	// finishing a sequence reports not busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && done) |=> (op_q == i2cms_pkg::OP_IDLE))
		else $error("done without returning to idle");

endmodule

`default_nettype wire

// ===== hdl/i2c_master_bit_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core: I2C master bit engine with stream channels
//
// Input stream (s_*): one request per item. s_tuser carries the command
// (tick, start, stop, write byte, read byte, ack, nack, wait ack); s_tdata
// carries the write byte and the sampled SDA level. Tick requests advance the
// current sequence; each SCL/SDA phase is held for ticks_per_phase ticks
// (zero counts as one), set by the user via cfg_we/cfg_wdata only while idle;
// the block does not enforce this. Output stream (m_*): one status item per
// request, carrying the pin levels, busy, done, received byte and ack level.
// A command that arrives while a sequence is running is dropped and produces
// no output item. Path: the request is registered, then worked by the engine
// into the output register (two register stages from s_* to m_*).
// Throughput: one request per cycle while m_tready does not hold the output;
// all the per-request work is one pass of short logic around the engine's
// state registers.
// Stall: an output item held by m_tready low freezes the engine; one more
// request waits in the input register, after which s_tready drops.
// Reset: SCL and SDA high, SDA driven, idle, ticks_per_phase = 2.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration: ticks_per_phase
	input  wire logic                          cfg_we,
	input  wire logic [i2cms_pkg::TICK_W-1:0]  cfg_wdata,
	// request stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [15:0]                   s_tdata,   // [7:0] tx_byte, [8] sda_in
	input  wire logic [i2cms_pkg::CMD_W-1:0]   s_tuser,   // [2:0] cmd
	// status stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [15:0]                        m_tdata    // [0] scl_level, [1] sda_level,
	                                                      // [2] sda_released, [3] busy_res,
	                                                      // [4] done_res, [12:5] rx_byte,
	                                                      // [13] ack_level
);

	logic [i2cms_pkg::TICK_W-1:0]        ticks_q;
	logic                                valid_s1;
	logic [i2cms_pkg::CMD_W-1:0]         cmd_s1;
	logic [i2cms_pkg::BITS_PER_BYTE-1:0] tx_byte_s1;
	logic                                sda_in_s1;
	logic                                advance;
	logic                                fire;
	logic                                has_result;
	i2cms_pkg::res_t                     res;
	logic                                out_valid_q;
	logic [15:0]                         out_data_q;

	// output register is free or being drained this cycle
	assign advance  = !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= i2cms_pkg::TICKS_RESET;
		end else if (cfg_we) begin
			ticks_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1     <= s_tuser;
			tx_byte_s1 <= s_tdata[7:0];
			sda_in_s1  <= s_tdata[8];
		end
	end

	i2cms_engine u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.cmd             (cmd_s1),
		.tx_byte         (tx_byte_s1),
		.sda_in          (sda_in_s1),
		.ticks_per_phase (ticks_q),
		.has_result      (has_result),
		.res             (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result) begin
			out_data_q <= {2'b00, res.ack_level, res.rx_byte, res.done_res,
			               res.busy_res, res.sda_released, res.sda_level, res.scl_level};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire
